// File: design/mlfd_pkg.sv
// Shared types and constants for the sync-word length-prefixed frame deframer.
// No dependencies; imported by every module of the block.
package mlfd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned MaxLenW = 16;
  localparam int unsigned LenW    = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  localparam logic [ByteW-1:0]   SyncFirstRst  = 8'hBE;
  localparam logic [ByteW-1:0]   SyncSecondRst = 8'hEF;
  localparam logic [MaxLenW-1:0] MaxLengthRst  = 16'd1024;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1,
    REG_MAX_LENGTH  = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_HUNT1  = 2'd0,
    PH_HUNT2  = 2'd1,
    PH_LENGTH = 2'd2,
    PH_DATA   = 2'd3
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0]   sync_first;
    logic [ByteW-1:0]   sync_second;
    logic [MaxLenW-1:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
    logic             status;
    logic             last;
  } res_t;

endpackage

// File: design/mlfd_in_if.sv
// Input word channel: one received byte per word, valid/ready handshake.
// Depends on mlfd_pkg for widths.
interface mlfd_in_if import mlfd_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: design/mlfd_out_if.sv
// Output word channel: payload byte or rejection, with status and last.
// Depends on mlfd_pkg for widths.
interface mlfd_out_if import mlfd_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             status;
  logic             last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

// File: design/mlfd_cfg_regs.sv
// Configuration registers: sync byte values and maximum payload length.
// Depends on mlfd_pkg.
module mlfd_cfg_regs import mlfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDatW-1:0] cfg_wdata_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SYNC_FIRST:  cfg_d.sync_first  = cfg_wdata_i[ByteW-1:0];
        REG_SYNC_SECOND: cfg_d.sync_second = cfg_wdata_i[ByteW-1:0];
        REG_MAX_LENGTH:  cfg_d.max_length  = cfg_wdata_i[MaxLenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first  <= SyncFirstRst;
      cfg_q.sync_second <= SyncSecondRst;
      cfg_q.max_length  <= MaxLengthRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/mlfd_parser.sv
// Frame parser: sync hunt, length gather and payload pass-through state machine.
// Depends on mlfd_pkg; one byte handled per step_i.
module mlfd_parser import mlfd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] rx_byte_i,
  input  cfg_t             cfg_i,
  output res_t             res_o
);

  phase_e               phase_q, phase_d;
  logic [LenW-1:0]      len_q, len_d;
  logic [MaxLenW-1:0]   cnt_q, cnt_d;
  logic [LenW-1:0]      len_new;
  logic [MaxLenW-1:0]   cnt_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT1;
      len_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

  assign cnt_inc = cnt_q + MaxLenW'(1);

  // little-endian length, byte lane picked by the count
  always_comb begin
    len_new = len_q;
    unique case (cnt_q[1:0])
      2'd0: len_new[7:0]   = len_q[7:0]   | rx_byte_i;
      2'd1: len_new[15:8]  = len_q[15:8]  | rx_byte_i;
      2'd2: len_new[23:16] = len_q[23:16] | rx_byte_i;
      default: len_new[31:24] = len_q[31:24] | rx_byte_i;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    res_o   = '0;
    if (step_i) begin
      unique case (phase_q)
        PH_HUNT1: begin
          if (rx_byte_i == cfg_i.sync_first) phase_d = PH_HUNT2;
        end
        PH_HUNT2: begin
          if (rx_byte_i == cfg_i.sync_second) begin
            phase_d = PH_LENGTH;
            len_d   = '0;
            cnt_d   = '0;
          end else begin
            phase_d = PH_HUNT1;
          end
        end
        PH_LENGTH: begin
          len_d = len_new;
          cnt_d = cnt_inc;
          if (cnt_q[1:0] == 2'd3) begin
            cnt_d = '0;
            if (len_new == '0 || len_new > LenW'(cfg_i.max_length)) begin
              phase_d      = PH_HUNT1;
              res_o.valid  = 1'b1;
              res_o.status = 1'b1;
              res_o.last   = 1'b1;
            end else begin
              phase_d = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          cnt_d       = cnt_inc;
          res_o.valid = 1'b1;
          res_o.data  = rx_byte_i;
          // accepted length never exceeds the 16-bit maximum
          if (cnt_inc >= len_q[MaxLenW-1:0]) begin
            phase_d    = PH_HUNT1;
            res_o.last = 1'b1;
          end
        end
        default: phase_d = PH_HUNT1;
      endcase
    end
  end

endmodule

// File: design/magic_length_frame_deframer_core.sv
// Top level of the sync-word length-prefixed frame deframer.
// Depends on mlfd_pkg, mlfd_in_if, mlfd_out_if, mlfd_cfg_regs, mlfd_parser.
//
// Usage:
//   in_chan carries one received byte per word. The block hunts for the two
//   sync bytes, gathers a 4-byte little-endian length, then forwards each
//   payload byte on out_chan with last set on the final one. A length of zero
//   or above max_length gives one word with status=1, last=1, out_byte=0.
//   Sync bytes and the length bytes of an accepted frame produce no output word.
//   Path: an accepted byte lands in the input register; its result word
//   (if any) is then registered in the output register and presented from there.
//   Throughput: one byte per cycle unless out_chan stalls; parser state update
//   is a single pass of compare and 16-bit count logic between in/out registers.
//   Stall: when out_chan.ready is low and a word is held, the input register
//   holds its byte and in_chan.ready drops once that register is full.
//   Reset (rst_ni low, async): registers return to 0xBE, 0xEF and 1024, the
//   parser hunts for the first sync byte, both word registers are emptied.
//   Configuration: cfg_we_i writes register cfg_idx_i (0 sync_first,
//   1 sync_second, 2 max_length); index 3 is ignored. Write while idle.
module magic_length_frame_deframer_core import mlfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  mlfd_in_if.sink            in_chan,
  mlfd_out_if.source         out_chan,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDatW-1:0] cfg_wdata_i
);

  cfg_t             cfg;
  res_t             res;
  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q;
  logic             status_q, last_q;
  logic             out_free, step, in_acc;

  mlfd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mlfd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rx_byte_i (in_byte_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  assign out_free      = !out_valid_q || out_chan.ready;
  assign step          = in_valid_q && out_free;
  assign in_chan.ready = !in_valid_q || step;
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign in_valid_d  = in_acc || (in_valid_q && !step);
  assign out_valid_d = (step && res.valid) || (out_valid_q && !out_chan.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) in_byte_q <= in_chan.rx_byte;
    if (step && res.valid) begin
      out_byte_q <= res.data;
      status_q   <= res.status;
      last_q     <= res.last;
    end
  end

  assign out_chan.valid    = out_valid_q;
  assign out_chan.out_byte = out_byte_q;
  assign out_chan.status   = status_q;
  assign out_chan.last     = last_q;

  a_reject_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q |-> last_q && out_byte_q == '0)
    else $error("rejection word without last or with nonzero byte");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && res.valid |=> out_valid_q)
    else $error("parser result not captured");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |-> !in_chan.ready)
    else $error("input taken while full and output stalled");

  a_held_byte_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step |=> in_valid_q && $stable(in_byte_q))
    else $error("pending input byte lost");

endmodule

// File: test/magic_length_frame_deframer_core_tb.sv
`timescale 1ns / 1ps
// Testbench for magic_length_frame_deframer_core: a directed table, then random frames
// over several register settings, with each output word checked against a local deframer.
// Depends on mlfd_pkg, mlfd_in_if, mlfd_out_if and the core.
module magic_length_frame_deframer_core_tb import mlfd_pkg::*;;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             status;
    logic             last;
  } word_t;

  typedef struct packed {
    logic [ByteW-1:0] rx;
    logic             pinned;
    logic             has_word;
    word_t            word;
  } stim_row_t;

  typedef struct packed {
    logic [CfgDatW-1:0] sync_first;
    logic [CfgDatW-1:0] sync_second;
    logic [CfgDatW-1:0] max_length;
  } cfg_plan_t;

  localparam int unsigned LenBytes      = 4;
  localparam int unsigned ItemsPerPhase = 310;
  localparam int unsigned NumPlans      = 5;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned WatchdogLimit = 2000;

  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  localparam word_t NoWord     = '{data: 8'h00, status: 1'b0, last: 1'b0};
  localparam word_t RejectWord = '{data: 8'h00, status: 1'b1, last: 1'b1};
  localparam word_t LastFF     = '{data: 8'hFF, status: 1'b0, last: 1'b1};

  // rx, pinned, has_word, word; pinned rows carry their own expected word
  localparam stim_row_t DirRows [0:21] = '{
    '{8'hBE, 1'b1, 1'b0, NoWord},      // first sync
    '{8'hBE, 1'b1, 1'b0, NoWord},      // second sync mismatch, dropped
    '{8'hEF, 1'b1, 1'b0, NoWord},      // still hunting
    '{8'hBE, 1'b1, 1'b0, NoWord},
    '{8'hEF, 1'b1, 1'b0, NoWord},
    '{8'h00, 1'b1, 1'b0, NoWord},
    '{8'h00, 1'b1, 1'b0, NoWord},
    '{8'h00, 1'b1, 1'b0, NoWord},
    '{8'h00, 1'b1, 1'b1, RejectWord},  // zero length
    '{8'hBE, 1'b0, 1'b0, NoWord},
    '{8'hEF, 1'b0, 1'b0, NoWord},
    '{8'h01, 1'b0, 1'b0, NoWord},
    '{8'h04, 1'b0, 1'b0, NoWord},
    '{8'h00, 1'b0, 1'b0, NoWord},
    '{8'h00, 1'b1, 1'b1, RejectWord},  // 1025 > max
    '{8'hBE, 1'b0, 1'b0, NoWord},
    '{8'hEF, 1'b0, 1'b0, NoWord},
    '{8'h01, 1'b0, 1'b0, NoWord},
    '{8'h00, 1'b0, 1'b0, NoWord},
    '{8'h00, 1'b0, 1'b0, NoWord},
    '{8'h00, 1'b0, 1'b0, NoWord},
    '{8'hFF, 1'b1, 1'b1, LastFF}       // one-byte frame
  };

  localparam cfg_plan_t CfgPlan [0:NumPlans-1] = '{
    '{16'hA55A, 16'h00A5, 16'h0001},
    '{16'hFF00, 16'h00FF, 16'hFFFF},
    '{16'h00FF, 16'h1200, 16'h0000},  // max_length zero
    '{16'h003C, 16'h803C, 16'd300},   // both sync values equal
    '{16'h00BE, 16'h00EF, 16'd1024}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDatW-1:0] cfg_wdata_i;

  mlfd_in_if  in_bus ();
  mlfd_out_if out_bus ();

  magic_length_frame_deframer_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan    (in_bus),
    .out_chan   (out_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // local deframer state
  cfg_t               live_cfg;
  phase_e             hunt_phase;
  logic [LenW-1:0]    len_acc;
  logic [MaxLenW-1:0] byte_cnt;

  word_t            expected_words [$];
  logic [ByteW-1:0] burst_bytes [$];
  int unsigned      mismatches   = 0;
  int unsigned      quiet_cycles = 0;
  bit               steady_in    = 1'b0;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit deframe_byte(input logic [ByteW-1:0] b, output word_t w);
    w = NoWord;
    deframe_byte = 1'b0;
    case (hunt_phase)
      PH_HUNT1: begin
        if (b == live_cfg.sync_first) hunt_phase = PH_HUNT2;
      end
      PH_HUNT2: begin
        if (b == live_cfg.sync_second) begin
          hunt_phase = PH_LENGTH;
          len_acc    = '0;
          byte_cnt   = '0;
        end else begin
          hunt_phase = PH_HUNT1;
        end
      end
      PH_LENGTH: begin
        len_acc  = len_acc | (LenW'(b) << (8 * byte_cnt[1:0]));
        byte_cnt = byte_cnt + 1'b1;
        if (byte_cnt >= MaxLenW'(LenBytes)) begin
          byte_cnt = '0;
          if (len_acc == '0 || len_acc > LenW'(live_cfg.max_length)) begin
            hunt_phase   = PH_HUNT1;
            w            = RejectWord;
            deframe_byte = 1'b1;
          end else begin
            hunt_phase = PH_DATA;
          end
        end
      end
      default: begin
        byte_cnt     = byte_cnt + 1'b1;
        w.data       = b;
        w.last       = (LenW'(byte_cnt) >= len_acc);
        deframe_byte = 1'b1;
        if (w.last) hunt_phase = PH_HUNT1;
      end
    endcase
  endfunction

  task automatic drive_byte(input logic [ByteW-1:0] b, input logic pinned,
                            input logic pin_has, input word_t pin_word);
    int unsigned gap;
    word_t       w;
    bit          has;
    gap = steady_in ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_bus.valid   <= 1'b1;
    in_bus.rx_byte <= b;
    do @(posedge clk_i); while (!in_bus.ready);
    has = deframe_byte(b, w);
    if (pinned) begin
      has = pin_has;
      w   = pin_word;
    end
    if (has) expected_words.push_back(w);
    if ($urandom_range(0, 99) == 0) steady_in = !steady_in;
  endtask

  task automatic hold_off(input int unsigned settle);
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SYNC_FIRST:  live_cfg.sync_first  = data[ByteW-1:0];
      REG_SYNC_SECOND: live_cfg.sync_second = data[ByteW-1:0];
      REG_MAX_LENGTH:  live_cfg.max_length  = data[MaxLenW-1:0];
      default: ;
    endcase
  endtask

  // good frame, rejected length, second sync mismatch, cut-off frame or noise
  task automatic build_burst(output bit counted);
    int unsigned      pick;
    int unsigned      cap;
    logic [LenW-1:0]  len;
    logic [ByteW-1:0] bad;
    burst_bytes.delete();
    counted = 1'b1;
    pick    = $urandom_range(0, 99);
    if (pick < 75) begin
      if (pick < 60 && live_cfg.max_length != '0) begin
        cap = ($urandom_range(0, 19) == 0) ? 200 : 8;
        if (cap > 32'(live_cfg.max_length)) cap = 32'(live_cfg.max_length);
        len = $urandom_range(1, cap);
      end else begin
        case ($urandom_range(0, 2))
          0:       len = '0;
          1:       len = LenW'(live_cfg.max_length) + 1;
          default: len = $urandom() | 32'h0001_0000;
        endcase
      end
      burst_bytes.push_back(live_cfg.sync_first);
      burst_bytes.push_back(live_cfg.sync_second);
      for (int k = 0; k < LenBytes; k++) burst_bytes.push_back(len[8*k +: 8]);
      if (len != '0 && len <= LenW'(live_cfg.max_length))
        repeat (len) burst_bytes.push_back(ByteW'($urandom_range(0, 255)));
    end else if (pick < 85) begin
      bad = ByteW'($urandom_range(0, 255));
      if (bad == live_cfg.sync_second) bad = bad ^ 8'h01;
      burst_bytes.push_back(live_cfg.sync_first);
      burst_bytes.push_back(bad);
    end else if (pick < 92) begin
      burst_bytes.push_back(live_cfg.sync_first);
      burst_bytes.push_back(live_cfg.sync_second);
      repeat ($urandom_range(1, 3)) burst_bytes.push_back(ByteW'($urandom_range(0, 255)));
    end else begin
      counted = 1'b0;
      repeat ($urandom_range(1, 4)) burst_bytes.push_back(ByteW'($urandom_range(0, 255)));
    end
  endtask

  initial begin : sink_pace
    int unsigned stall;
    bit          steady;
    stall         = 0;
    steady        = 1'b0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 199) == 0) steady = !steady;
      if (stall > 0) begin
        stall--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        if (!steady) stall = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin : word_check
    word_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        $error("unexpected word: out_byte=%02h status=%0b last=%0b",
               out_bus.out_byte, out_bus.status, out_bus.last);
      end else begin
        want = expected_words.pop_front();
        if (out_bus.out_byte !== want.data) begin
          mismatches++;
          $error("out_byte: expected %02h, got %02h", want.data, out_bus.out_byte);
        end
        if (out_bus.status !== want.status) begin
          mismatches++;
          $error("status: expected %0b, got %0b", want.status, out_bus.status);
        end
        if (out_bus.last !== want.last) begin
          mismatches++;
          $error("last: expected %0b, got %0b", want.last, out_bus.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || cfg_we_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("FAIL magic_length_frame_deframer_core");
        $finish;
      end
    end
  end

  initial begin : run
    int unsigned counted_items;
    int unsigned pause_at;
    bit          counts;
    rst_ni         = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.rx_byte = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = REG_SYNC_FIRST;
    cfg_wdata_i    = '0;
    live_cfg       = '{sync_first: SyncFirstRst, sync_second: SyncSecondRst,
                       max_length: MaxLengthRst};
    hunt_phase     = PH_HUNT1;
    len_acc        = '0;
    byte_cnt       = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DirRows[i])
      drive_byte(DirRows[i].rx, DirRows[i].pinned, DirRows[i].has_word, DirRows[i].word);

    for (int p = 0; p <= NumPlans; p++) begin
      if (p > 0) begin
        hold_off(SettleCycles);
        if (p == 1) write_reg(RegUnused, 16'hFFFF);
        write_reg(REG_SYNC_FIRST,  CfgPlan[p-1].sync_first);
        write_reg(REG_SYNC_SECOND, CfgPlan[p-1].sync_second);
        write_reg(REG_MAX_LENGTH,  CfgPlan[p-1].max_length);
      end
      counted_items = 0;
      pause_at      = $urandom_range(50, 250);
      while (counted_items < ItemsPerPhase) begin
        build_burst(counts);
        foreach (burst_bytes[k]) drive_byte(burst_bytes[k], 1'b0, 1'b0, NoWord);
        if (counts) counted_items += burst_bytes.size();
        // sender waits for the output side to drain once per setting
        if (pause_at != 0 && counted_items >= pause_at) begin
          hold_off(0);
          pause_at = 0;
        end
      end
    end

    hold_off(DrainCycles);
    if (mismatches == 0) begin
      $display("PASS magic_length_frame_deframer_core");
    end else begin
      $display("FAIL magic_length_frame_deframer_core");
    end
    $finish;
  end

endmodule
